// ----- rtl/tfp_pkg.sv -----
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared types and constants of the teleinformation frame parser: character
// codes, result kinds and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package tfp_pkg;

  localparam int LABEL_MAX_DEF = 8;
  localparam int DATA_MAX_DEF  = 16;

  localparam logic [6:0] CH_STX = 7'h02;
  localparam logic [6:0] CH_ETX = 7'h03;
  localparam logic [6:0] CH_LF  = 7'h0A;
  localparam logic [6:0] CH_CR  = 7'h0D;
  localparam logic [6:0] CH_SP  = 7'h20;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_EOF  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_LABEL = 2'd1,
    SEL_DATA  = 2'd2
  } char_sel_t;

  typedef struct packed {
    logic      cur_clr;
    logic      cur_inc;
    logic      sum_clr;
    logic      sum_add;
    logic      len_ld;
    logic      lab_we;
    logic      dat_we;
    logic      idx_clr;
    logic      idx_inc;
    logic      out_load;
    kind_t     out_kind;
    logic      out_in_label;
    char_sel_t out_sel;
    logic      out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic is_stx;
    logic is_etx;
    logic is_lf;
    logic is_cr;
    logic is_sp;
    logic chk_ok;
    logic cur_lt_label;
    logic cur_lt_data;
    logic label_empty;
    logic data_empty;
    logic idx_last_label;
    logic idx_last_data;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/tfp_ram.sv -----
// ----------------------------------------------------------------------------
// tfp_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tfp_ram #(
  parameter  int WIDTH = 7,
  parameter  int DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tfp_datapath.sv -----
// ----------------------------------------------------------------------------
// tfp_datapath
// Field cursor, label length, running checksum, label and data stores,
// read-out index and the result register of the frame parser.
// ----------------------------------------------------------------------------
module tfp_datapath #(
  parameter int LABEL_MAX = tfp_pkg::LABEL_MAX_DEF,
  parameter int DATA_MAX  = tfp_pkg::DATA_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          rx_byte,
  input  tfp_pkg::dp_cmd_t    cmd,
  output tfp_pkg::dp_status_t status,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output logic                out_in_label,
  output logic [6:0]          out_char_value,
  output logic                out_last
);

  import tfp_pkg::*;

  localparam int CUR_MAX = (LABEL_MAX > DATA_MAX) ? LABEL_MAX : DATA_MAX;
  localparam int CUR_W   = $clog2(CUR_MAX + 1);
  localparam int LEN_W   = $clog2(LABEL_MAX + 1);
  localparam int LAB_AW  = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int DAT_AW  = (DATA_MAX > 1) ? $clog2(DATA_MAX) : 1;

  logic [6:0]       ch;
  logic [CUR_W-1:0] cursor_r, cursor_nxt;
  logic [LEN_W-1:0] label_len_r, label_len_nxt;
  logic [5:0]       sum_r, sum_nxt;
  logic [CUR_W-1:0] idx_r, idx_nxt;
  logic [CUR_W-1:0] idx_plus1;
  logic [6:0]       lab_rdata, dat_rdata;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       kind_r;
  logic             in_label_r;
  logic [6:0]       char_r;
  logic             last_r;
  logic [6:0]       char_sel;

  assign ch        = rx_byte[6:0];
  assign idx_plus1 = idx_r + CUR_W'(1);

  always_comb begin
    cursor_nxt = cursor_r;
    if (cmd.cur_clr) begin
      cursor_nxt = '0;
    end else if (cmd.cur_inc) begin
      cursor_nxt = cursor_r + CUR_W'(1);
    end

    label_len_nxt = cmd.len_ld ? LEN_W'(cursor_r) : label_len_r;

    sum_nxt = sum_r;
    if (cmd.sum_clr) begin
      sum_nxt = '0;
    end else if (cmd.sum_add) begin
      sum_nxt = sum_r + ch[5:0];
    end

    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_plus1;
    end
  end

  tfp_ram #(.WIDTH(7), .DEPTH(LABEL_MAX)) u_label_ram (
    .clk   (clk),
    .we    (cmd.lab_we),
    .waddr (cursor_r[LAB_AW-1:0]),
    .wdata (ch),
    .raddr (idx_nxt[LAB_AW-1:0]),
    .rdata (lab_rdata)
  );

  tfp_ram #(.WIDTH(7), .DEPTH(DATA_MAX)) u_data_ram (
    .clk   (clk),
    .we    (cmd.dat_we),
    .waddr (cursor_r[DAT_AW-1:0]),
    .wdata (ch),
    .raddr (idx_nxt[DAT_AW-1:0]),
    .rdata (dat_rdata)
  );

  always_comb begin
    unique case (cmd.out_sel)
      SEL_LABEL: char_sel = lab_rdata;
      SEL_DATA:  char_sel = dat_rdata;
      default:   char_sel = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      label_len_r <= '0;
      sum_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r    <= cursor_nxt;
      label_len_r <= label_len_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind_r     <= cmd.out_kind;
      in_label_r <= cmd.out_in_label;
      char_r     <= char_sel;
      last_r     <= cmd.out_last;
    end
  end

  assign status.is_stx         = (ch == CH_STX);
  assign status.is_etx         = (ch == CH_ETX);
  assign status.is_lf          = (ch == CH_LF);
  assign status.is_cr          = (ch == CH_CR);
  assign status.is_sp          = (ch == CH_SP);
  assign status.chk_ok         = ((7'({1'b0, sum_r}) + CH_SP) == ch);
  assign status.cur_lt_label   = (cursor_r < CUR_W'(LABEL_MAX));
  assign status.cur_lt_data    = (cursor_r < CUR_W'(DATA_MAX));
  assign status.label_empty    = (label_len_r == '0);
  assign status.data_empty     = (cursor_r == '0);
  assign status.idx_last_label = (idx_plus1 == CUR_W'(label_len_r));
  assign status.idx_last_data  = (idx_plus1 == cursor_r);
  assign status.out_free       = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_in_label   = in_label_r;
  assign out_char_value = char_r;
  assign out_last       = last_r;

endmodule

// ----- rtl/tfp_ctrl.sv -----
// ----------------------------------------------------------------------------
// tfp_ctrl
// Parse and read-out state machine of the frame parser: classifies each
// accepted beat and sequences the result run of a good group.
// ----------------------------------------------------------------------------
module tfp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tfp_pkg::dp_status_t status,
  output tfp_pkg::dp_cmd_t    cmd
);

  import tfp_pkg::*;

  typedef enum logic [8:0] {
    ST_WAIT_STX   = 9'b000000001,
    ST_WAIT_LF    = 9'b000000010,
    ST_LABEL      = 9'b000000100,
    ST_DATA       = 9'b000001000,
    ST_CHECK      = 9'b000010000,
    ST_WAIT_CR    = 9'b000100000,
    ST_EMIT_LABEL = 9'b001000000,
    ST_EMIT_DATA  = 9'b010000000,
    ST_EMIT_END   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   parsing;
  logic   fire;

  assign parsing  = (state_r == ST_WAIT_STX) || (state_r == ST_WAIT_LF) ||
                    (state_r == ST_LABEL) || (state_r == ST_DATA) ||
                    (state_r == ST_CHECK) || (state_r == ST_WAIT_CR);
  assign in_ready = parsing && status.out_free;
  assign fire     = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_WAIT_STX: begin
        if (fire && status.is_stx) begin
          state_nxt = ST_WAIT_LF;
        end
      end
      ST_WAIT_LF: begin
        if (fire) begin
          if (status.is_lf) begin
            cmd.cur_clr = 1'b1;
            cmd.sum_clr = 1'b1;
            state_nxt   = ST_LABEL;
          end else if (status.is_etx) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = KIND_EOF;
            cmd.out_last = 1'b1;
            state_nxt    = ST_WAIT_STX;
          end else begin
            state_nxt = ST_WAIT_STX;
          end
        end
      end
      ST_LABEL: begin
        if (fire) begin
          if (status.is_sp) begin
            cmd.len_ld  = 1'b1;
            cmd.cur_clr = 1'b1;
            cmd.sum_add = 1'b1;
            state_nxt   = ST_DATA;
          end else if (status.cur_lt_label) begin
            cmd.lab_we  = 1'b1;
            cmd.cur_inc = 1'b1;
            cmd.sum_add = 1'b1;
          end else begin
            state_nxt = ST_WAIT_STX;
          end
        end
      end
      ST_DATA: begin
        if (fire) begin
          if (status.is_sp) begin
            state_nxt = ST_CHECK;
          end else if (status.cur_lt_data) begin
            cmd.dat_we  = 1'b1;
            cmd.cur_inc = 1'b1;
            cmd.sum_add = 1'b1;
          end else begin
            state_nxt = ST_WAIT_STX;
          end
        end
      end
      ST_CHECK: begin
        if (fire) begin
          if (status.chk_ok) begin
            state_nxt = ST_WAIT_CR;
          end else begin
            cmd.out_load = 1'b1;
            cmd.out_kind = KIND_ERR;
            cmd.out_last = 1'b1;
            state_nxt    = ST_WAIT_STX;
          end
        end
      end
      ST_WAIT_CR: begin
        if (fire) begin
          if (status.is_cr) begin
            cmd.idx_clr = 1'b1;
            if (!status.label_empty) begin
              state_nxt = ST_EMIT_LABEL;
            end else if (!status.data_empty) begin
              state_nxt = ST_EMIT_DATA;
            end else begin
              state_nxt = ST_EMIT_END;
            end
          end else begin
            state_nxt = ST_WAIT_STX;
          end
        end
      end
      ST_EMIT_LABEL: begin
        if (status.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_kind     = KIND_CHAR;
          cmd.out_in_label = 1'b1;
          cmd.out_sel      = SEL_LABEL;
          if (status.idx_last_label) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = status.data_empty ? ST_EMIT_END : ST_EMIT_DATA;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      ST_EMIT_DATA: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_CHAR;
          cmd.out_sel  = SEL_DATA;
          if (status.idx_last_data) begin
            state_nxt = ST_EMIT_END;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      ST_EMIT_END: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_END;
          cmd.out_last = 1'b1;
          state_nxt    = ST_WAIT_LF;
        end
      end
      default: begin
        state_nxt = ST_WAIT_STX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT_STX;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result loaded while output register is full");

  a_end_then_wait_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.out_kind == KIND_END) |=> (state_r == ST_WAIT_LF))
    else $error("end marker not followed by wait for next group");

  a_no_input_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.out_kind == KIND_CHAR) |-> !in_ready)
    else $error("input accepted during group read-out");

  a_err_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.out_kind == KIND_ERR) |-> (state_r == ST_CHECK))
    else $error("checksum error outside checksum state");

endmodule

// ----- rtl/teleinfo_frame_parser_unit.sv -----
// ----------------------------------------------------------------------------
// teleinfo_frame_parser_unit
// Historic-mode teleinformation frame parser.
//
// Input channel (in_valid/in_ready/in_rx_byte) takes one serial character per
// beat; bit 7 is ignored. Result channel (out_valid/out_ready/out_*) gives
// group characters, group end markers, end-of-frame and checksum errors;
// out_last marks the final result caused by one input beat.
// A character that causes no result is absorbed. ETX and a checksum
// error give their single result in the cycle after the beat.
// The CR of a good group starts a read-out of label then data characters
// from the two stores, one result per cycle unless the receiver stalls,
// then the end marker: label_len + data_len + 1 results, at most
// LABEL_MAX + DATA_MAX + 1. The registered store read runs one index ahead.
// in_ready is low during a read-out and while the result register is full
// and not being taken, so a stalled receiver holds both sides.
// Reset returns to waiting for STX with the result register empty; the
// stores need no clearing.
// ----------------------------------------------------------------------------
module teleinfo_frame_parser_unit #(
  parameter int LABEL_MAX = tfp_pkg::LABEL_MAX_DEF,
  parameter int DATA_MAX  = tfp_pkg::DATA_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic       out_in_label,
  output logic [6:0] out_char_value,
  output logic       out_last
);

  import tfp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tfp_datapath #(
    .LABEL_MAX (LABEL_MAX),
    .DATA_MAX  (DATA_MAX)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_byte        (in_rx_byte),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_in_label   (out_in_label),
    .out_char_value (out_char_value),
    .out_last       (out_last)
  );

endmodule
